// ----- design/sfr_pkg.sv -----
// Shared types and constants for the stream find-and-replace block.
// Used by sfr_front, sfr_queue, sfr_back and stream_find_replace_unit.
// No dependencies.
package sfr_pkg;

    localparam int DEFAULT_MAX_PATTERN     = 8;
    localparam int DEFAULT_MAX_REPLACEMENT = 8;
    localparam int DEFAULT_QUEUE_DEPTH     = 4;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 64;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES      = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH     = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_BYTES  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_LENGTH = 8'd3;

    localparam logic ACTION_DATA  = 1'b0;
    localparam logic ACTION_FLUSH = 1'b1;
    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_END     = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] out_byte;
        logic       last;
    } out_item_t;

    // Work handed from the front to the back
    typedef enum logic [1:0] {
        JOB_BYTE,
        JOB_REPL,
        JOB_FLUSH
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [63:0] data;
        logic [3:0]  count;
    } job_t;

endpackage

// ----- design/stream_find_replace_unit.sv -----
// Top level of the stream find-and-replace block.
// Depends on sfr_pkg, sfr_front, sfr_queue and sfr_back.
//
// Usage:
//   s_valid/s_ready/s_item carry input items: a data byte or an end-of-string
//   flush. m_valid/m_ready/m_item carry result items: characters and the end
//   marker, with last set on the final result caused by an input item.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the four registers
//   (pattern bytes, pattern length, replacement bytes, replacement length);
//   cfg_ready is always high. Write them only while the block is idle.
//   Path: an accepted item is classified by the front combinationally and
//   queued at the accepting edge; the back later loads its results from the
//   queue head into the output register, behind any older queued jobs.
//   Throughput: one input item per cycle while each item causes at most one
//   result and m_ready stays high. The back emits a replacement at one byte
//   per cycle while m_ready is high, a flush as the window bytes and the end
//   marker; the four-entry queue absorbs bursts; s_ready drops only when full.
//   Reset: window empty, pattern length 1, other registers zero, queue and
//   output register empty.
//   Stall: when m_ready is low the output register holds, the back stops,
//   the queue fills, and then input is held off.
module stream_find_replace_unit
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN     = DEFAULT_MAX_PATTERN,
    parameter int MAX_REPLACEMENT = DEFAULT_MAX_REPLACEMENT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_item,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_item
);

    logic push;
    job_t push_job;
    logic q_full;
    logic q_valid;
    job_t q_head;
    logic q_pop;

    // Registers are plain flops: always take the write
    assign cfg_ready = 1'b1;

    // Front: hold the window, compare against the pattern, classify
    sfr_front #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    // Queue: decouple classification from expansion
    sfr_queue #(
        .DEPTH (DEFAULT_QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .q_valid  (q_valid),
        .head     (q_head),
        .pop      (q_pop)
    );

    // Back: expand each job into result items
    sfr_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .head    (q_head),
        .pop     (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

// ----- design/sfr_front.sv -----
// Front part: configuration registers, match window and item classification.
// Depends on sfr_pkg. Produces one job per item that causes results.
module sfr_front
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN     = DEFAULT_MAX_PATTERN,
    parameter int MAX_REPLACEMENT = DEFAULT_MAX_REPLACEMENT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_item,
    input  logic                   q_full,
    output logic                   push,
    output job_t                   push_job
);

    logic [63:0] pattern_reg;
    logic [3:0]  plen_reg;
    logic [63:0] repl_reg;
    logic [3:0]  rlen_reg;

    logic [7:0]  win_reg  [MAX_PATTERN];
    logic [7:0]  win_next [MAX_PATTERN];
    logic [3:0]  fill_reg;
    logic [3:0]  fill_next;

    logic [7:0]  ext [MAX_PATTERN];
    logic [3:0]  plen;
    logic [3:0]  rlen;
    logic [3:0]  fill;
    logic [3:0]  fill_inc;
    logic        match;
    logic        accept;
    logic        plen_write;
    logic [63:0] flush_data;

    assign s_ready    = !q_full;
    assign accept     = s_valid && s_ready;
    assign plen_write = cfg_valid && (cfg_index == REG_PATTERN_LENGTH);

    always_comb begin
        if (plen_reg == 4'd0) begin
            plen = 4'd1;
        end else if (plen_reg > 4'(MAX_PATTERN)) begin
            plen = 4'(MAX_PATTERN);
        end else begin
            plen = plen_reg;
        end
        rlen = (rlen_reg > 4'(MAX_REPLACEMENT)) ? 4'(MAX_REPLACEMENT) : rlen_reg;
    end

    always_comb begin
        fill     = (fill_reg >= plen) ? 4'd0 : fill_reg;
        fill_inc = fill + 4'd1;
        match    = 1'b1;
        flush_data = '0;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (4'(k) < fill) begin
                ext[k] = win_reg[k];
            end else if (4'(k) == fill) begin
                ext[k] = s_item.data_byte;
            end else begin
                ext[k] = 8'h00;
            end
            if ((4'(k) < plen) && (ext[k] != pattern_reg[8*k +: 8])) begin
                match = 1'b0;
            end
            flush_data[8*k +: 8] = win_reg[k];
        end
    end

    always_comb begin
        win_next       = win_reg;
        fill_next      = fill_reg;
        push           = 1'b0;
        push_job.kind  = JOB_BYTE;
        push_job.data  = '0;
        push_job.count = 4'd1;
        if (accept) begin
            if (s_item.action == ACTION_FLUSH) begin
                // Drain the window, then the end marker
                push           = 1'b1;
                push_job.kind  = JOB_FLUSH;
                push_job.data  = flush_data;
                push_job.count = fill;
                for (int k = 0; k < MAX_PATTERN; k++) begin
                    win_next[k] = 8'h00;
                end
                fill_next = 4'd0;
            end else if (fill_inc >= plen) begin
                if (match) begin
                    push           = (rlen != 4'd0);
                    push_job.kind  = JOB_REPL;
                    push_job.data  = repl_reg;
                    push_job.count = rlen;
                    for (int k = 0; k < MAX_PATTERN; k++) begin
                        win_next[k] = 8'h00;
                    end
                    fill_next = 4'd0;
                end else begin
                    // Release the oldest byte and shift the window down
                    push                = 1'b1;
                    push_job.kind       = JOB_BYTE;
                    push_job.data[7:0]  = ext[0];
                    push_job.count      = 4'd1;
                    for (int k = 0; k < MAX_PATTERN - 1; k++) begin
                        win_next[k] = ext[k+1];
                    end
                    win_next[MAX_PATTERN-1] = 8'h00;
                    fill_next = fill;
                end
            end else begin
                win_next  = ext;
                fill_next = fill_inc;
            end
        end
        if (plen_write) begin
            // New length: drop whatever the window holds
            for (int k = 0; k < MAX_PATTERN; k++) begin
                win_next[k] = 8'h00;
            end
            fill_next = 4'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            plen_reg    <= 4'd1;
            repl_reg    <= '0;
            rlen_reg    <= 4'd0;
            fill_reg    <= 4'd0;
            for (int k = 0; k < MAX_PATTERN; k++) begin
                win_reg[k] <= 8'h00;
            end
        end else begin
            win_reg  <= win_next;
            fill_reg <= fill_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_PATTERN_BYTES: begin
                        pattern_reg <= cfg_data;
                    end
                    REG_PATTERN_LENGTH: begin
                        plen_reg <= cfg_data[3:0];
                    end
                    REG_REPLACEMENT_BYTES: begin
                        repl_reg <= cfg_data;
                    end
                    REG_REPLACEMENT_LENGTH: begin
                        rlen_reg <= cfg_data[3:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    a_fill_below_plen: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg < plen)
        else $error("window fill reached the pattern length");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && q_full))
        else $error("job pushed into a full queue");

endmodule

// ----- design/sfr_queue.sv -----
// Short job queue between the front and back parts.
// Depends on sfr_pkg for the job type.
module sfr_queue
    import sfr_pkg::*;
#(
    parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    output logic q_valid,
    output job_t head,
    input  logic pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = mem[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

endmodule

// ----- design/sfr_back.sv -----
// Back part: expands queued jobs into result items in an output register,
// one per cycle unless m_ready stalls it. Depends on sfr_pkg.
module sfr_back
    import sfr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    input  job_t      head,
    output logic      pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic [2:0] idx_reg;
    logic       m_valid_reg;
    out_item_t  m_item_reg;

    logic [3:0] idx4;
    logic [7:0] lane;
    logic       load;
    logic       fire;
    logic       done;
    out_item_t  res;

    assign idx4 = {1'b0, idx_reg};
    assign lane = head.data[{idx_reg, 3'b000} +: 8];
    assign load = !m_valid_reg || m_ready;
    assign fire = q_valid && load;
    assign pop  = fire && done;

    always_comb begin
        res.out_kind = KIND_CHAR;
        res.out_byte = lane;
        res.last     = 1'b0;
        done         = 1'b0;
        case (head.kind)
            JOB_FLUSH: begin
                if (idx4 == head.count) begin
                    res.out_kind = KIND_END;
                    res.out_byte = 8'h00;
                    res.last     = 1'b1;
                    done         = 1'b1;
                end
            end
            default: begin
                res.last = (idx4 + 4'd1 == head.count);
                done     = res.last;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= 3'd0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
            idx_reg     <= done ? 3'd0 : idx_reg + 3'd1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_item_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    a_marker_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_item_reg.out_kind == KIND_END)) |-> m_item_reg.last)
        else $error("end marker without last");

    a_idx_in_job: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && (head.kind != JOB_FLUSH)) |-> (idx4 < head.count))
        else $error("byte index ran past the job");

endmodule

// ----- test/stream_find_replace_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for stream_find_replace_unit: directed table, then random phases.
// Depends on sfr_pkg and the stream_find_replace_unit RTL.
module stream_find_replace_unit_tb;
    import sfr_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int SETTLE_CYCLES = 8;    // covers accept -> queue -> output register
    localparam int HOLD_CYCLES   = 120;  // long receiver hold-off
    localparam int RANDOM_ITEMS  = 345;
    localparam int IDLE_PERCENT  = 27;
    localparam int PRINT_CAP     = 40;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 8'hA5;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_item    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_item_t              m_item;

    stream_find_replace_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // Shadow copy of the registers and the match window, at reset values
    logic [63:0] pat_bytes = '0;
    logic [3:0]  pat_len   = 4'd1;
    logic [63:0] rep_bytes = '0;
    logic [3:0]  rep_len   = 4'd0;
    logic [63:0] win_bytes = '0;
    int unsigned win_fill  = 0;

    out_item_t pending_chars[$];   // expected output items, oldest first

    int errors       = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int reg_writes   = 0;
    int match_count  = 0;
    int flush_count  = 0;

    // Flow control knobs; the receiver owns hold_seen and hold_left
    bit gaps_on   = 1'b1;
    bit stall_on  = 1'b1;
    int hold_asks = 0;
    int hold_seen = 0;
    int hold_left = 0;

    function automatic out_item_t make_result(logic kind, logic [7:0] b, logic l);
        out_item_t r;
        r.out_kind = kind;
        r.out_byte = b;
        r.last     = l;
        return r;
    endfunction

    function automatic in_item_t make_item(logic action, logic [7:0] b);
        in_item_t it;
        it.action    = action;
        it.data_byte = b;
        return it;
    endfunction

    // Zero acts as one, anything above eight as eight
    function automatic int unsigned match_len();
        int unsigned n;
        n = pat_len;
        if (n == 0) n = 1;
        if (n > 8) n = 8;
        return n;
    endfunction

    function automatic logic [63:0] low_bytes_mask(int unsigned n);
        if (n >= 8) return '1;
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    // Advance the window by one input item; fill res with the items it causes
    function automatic int find_replace_step(input in_item_t it, output out_item_t res[8]);
        int unsigned plen;
        int unsigned fill;
        int unsigned rlen;
        int          n;
        logic [63:0] m;
        plen = match_len();
        fill = win_fill;
        n    = 0;
        for (int k = 0; k < 8; k++) res[k] = '0;
        if (fill >= plen) begin
            fill      = 0;
            win_bytes = '0;
        end
        if (it.action == ACTION_FLUSH) begin
            for (int unsigned k = 0; k < fill; k++) begin
                res[n] = make_result(KIND_CHAR, win_bytes[8*k +: 8], 1'b0);
                n++;
            end
            res[n] = make_result(KIND_END, 8'h00, 1'b0);
            n++;
            win_bytes = '0;
            fill      = 0;
            flush_count++;
        end else begin
            win_bytes &= low_bytes_mask(fill);
            win_bytes |= {56'd0, it.data_byte} << (8 * fill);
            fill++;
            if (fill >= plen) begin
                m = low_bytes_mask(plen);
                if ((win_bytes & m) == (pat_bytes & m)) begin
                    rlen = (rep_len > 8) ? 8 : rep_len;
                    for (int unsigned k = 0; k < rlen; k++) begin
                        res[n] = make_result(KIND_CHAR, rep_bytes[8*k +: 8], 1'b0);
                        n++;
                    end
                    win_bytes = '0;
                    fill      = 0;
                    match_count++;
                end else begin
                    res[n] = make_result(KIND_CHAR, win_bytes[7:0], 1'b0);
                    n++;
                    win_bytes = win_bytes >> 8;
                    fill--;
                end
            end
        end
        win_fill = fill;
        if (n > 0) res[n-1].last = 1'b1;
        return n;
    endfunction

    task automatic report(input string what);
        errors++;
        if (errors <= PRINT_CAP) $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // Compare each accepted output item with the oldest expectation
    always @(posedge aclk) begin
        out_item_t w;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_chars.size() == 0) begin
                report($sformatf("unexpected item kind %0b byte %02h last %0b",
                                 m_item.out_kind, m_item.out_byte, m_item.last));
            end else begin
                w = pending_chars.pop_front();
                if (m_item.out_kind !== w.out_kind)
                    report($sformatf("item %0d out_kind %0b, expected %0b",
                                     results_seen, m_item.out_kind, w.out_kind));
                if (m_item.out_byte !== w.out_byte)
                    report($sformatf("item %0d out_byte %02h, expected %02h",
                                     results_seen, m_item.out_byte, w.out_byte));
                if (m_item.last !== w.last)
                    report($sformatf("item %0d last %0b, expected %0b",
                                     results_seen, m_item.last, w.last));
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request, counted here
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_asks) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= !(stall_on && ($urandom_range(99) < IDLE_PERCENT));
        end
    end

    // Drop valid, wait for every expected item, then let in-flight work finish
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_chars.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_PATTERN_BYTES:      pat_bytes = value;
            REG_PATTERN_LENGTH: begin
                // a length write drops whatever the window holds
                pat_len   = value[3:0];
                win_bytes = '0;
                win_fill  = 0;
            end
            REG_REPLACEMENT_BYTES:  rep_bytes = value;
            REG_REPLACEMENT_LENGTH: rep_len   = value[3:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Offer one item; on acceptance queue the typed or predicted items
    task automatic push_item(input in_item_t it, input bit typed, input out_item_t want);
        out_item_t res[8];
        int        n;
        while (gaps_on && ($urandom_range(99) < IDLE_PERCENT)) begin
            s_valid <= 1'b0;
            s_item  <= make_item(1'($urandom_range(1)), 8'($urandom_range(255)));
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        n = find_replace_step(it, res);
        items_sent++;
        if (typed) begin
            pending_chars.push_back(want);
        end else begin
            for (int i = 0; i < n; i++) pending_chars.push_back(res[i]);
        end
        @(negedge aclk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        push_item(make_item(ACTION_DATA, b), 1'b0, '0);
    endtask

    // Directed stimulus table
    typedef struct {
        bit                     is_write;
        logic [CFG_INDEX_W-1:0] idx;
        logic [63:0]            value;
        in_item_t               item;
        bit                     typed;
        out_item_t              want;
    } script_row_t;

    script_row_t script[$];

    function automatic void add_write(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
        script_row_t r;
        r          = '{default: '0};
        r.is_write = 1'b1;
        r.idx      = idx;
        r.value    = value;
        script.push_back(r);
    endfunction

    function automatic void add_item(input logic action, input logic [7:0] b,
                                     input bit typed, input out_item_t want);
        script_row_t r;
        r       = '{default: '0};
        r.item  = make_item(action, b);
        r.typed = typed;
        r.want  = want;
        script.push_back(r);
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_item(ACTION_DATA, s[i], 1'b0, '0);
    endfunction

    function automatic void build_script();
        // reset settings: pattern is one zero byte, matches are deleted
        add_item(ACTION_DATA, 8'hFF, 1'b1, make_result(KIND_CHAR, 8'hFF, 1'b1));
        add_item(ACTION_DATA, 8'h00, 1'b0, '0);
        add_item(ACTION_FLUSH, 8'h00, 1'b1, make_result(KIND_END, 8'h00, 1'b1));
        // "abc" -> "XY", with a false start that shifts the window
        add_write(REG_PATTERN_BYTES, 64'h636261);
        add_write(REG_PATTERN_LENGTH, 64'd3);
        add_write(REG_REPLACEMENT_BYTES, 64'h5958);
        add_write(REG_REPLACEMENT_LENGTH, 64'd2);
        add_text("ababcd");
        add_item(ACTION_FLUSH, 8'hFF, 1'b0, '0);
        // replacement length zero deletes the match
        add_write(REG_REPLACEMENT_LENGTH, 64'd0);
        add_text("abc");
        add_item(ACTION_FLUSH, 8'h55, 1'b1, make_result(KIND_END, 8'h00, 1'b1));
        // oversized lengths clamp to eight; flush a seven-byte window
        add_write(REG_PATTERN_BYTES, '1);
        add_write(REG_PATTERN_LENGTH, 64'd15);
        add_write(REG_REPLACEMENT_BYTES, 64'h0123_4567_89AB_CDEF);
        add_write(REG_REPLACEMENT_LENGTH, 64'd15);
        add_write(REG_UNUSED, 64'hDEAD_BEEF_0000_FFFF);
        add_item(ACTION_DATA, 8'h00, 1'b0, '0);
        add_item(ACTION_DATA, 8'hFF, 1'b0, '0);
        add_item(ACTION_DATA, 8'h80, 1'b0, '0);
        add_item(ACTION_DATA, 8'h7F, 1'b0, '0);
        add_item(ACTION_DATA, 8'hFF, 1'b0, '0);
        add_item(ACTION_DATA, 8'hFF, 1'b0, '0);
        add_item(ACTION_DATA, 8'hFF, 1'b0, '0);
        add_item(ACTION_FLUSH, 8'h00, 1'b0, '0);
        // zero pattern length acts as one: a single byte match gives eight items
        add_write(REG_PATTERN_LENGTH, 64'd0);
        add_item(ACTION_DATA, 8'hFF, 1'b0, '0);
        add_item(ACTION_DATA, 8'h00, 1'b1, make_result(KIND_CHAR, 8'h00, 1'b1));
        // length write with a byte in the window discards it
        add_write(REG_PATTERN_LENGTH, 64'd2);
        add_item(ACTION_DATA, 8'hFF, 1'b0, '0);
        add_write(REG_PATTERN_LENGTH, 64'd2);
        add_item(ACTION_FLUSH, 8'h00, 1'b1, make_result(KIND_END, 8'h00, 1'b1));
    endfunction

    function automatic logic [63:0] pick_pattern_bytes(input int phase);
        case (phase % 5)
            0:       return '1;
            1:       return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [3:0] pick_pattern_len();
        case ($urandom_range(9))
            0:       return 4'd0;
            1:       return 4'd15;
            2:       return 4'd8;
            default: return 4'($urandom_range(1, 5));
        endcase
    endfunction

    // Mostly whole or partial pattern runs, with loose bytes and flushes mixed in
    task automatic send_random_phase(input int count, input bit drain_mid);
        int          sent;
        int          r;
        int unsigned plen;
        int unsigned cut;
        bit          drained;
        sent    = 0;
        drained = 1'b0;
        plen    = match_len();
        while (sent < count) begin
            if (drain_mid && !drained && sent >= count / 2) begin
                settle();
                drained = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 8) begin
                push_item(make_item(ACTION_FLUSH, 8'($urandom_range(255))), 1'b0, '0);
                sent++;
            end else if (r < 40) begin
                cut = (r < 30) ? plen : $urandom_range(1, plen);
                for (int unsigned k = 0; k < cut; k++) send_byte(pat_bytes[8*k +: 8]);
                sent += cut;
            end else if (r < 80) begin
                send_byte(pat_bytes[8*$urandom_range(0, plen - 1) +: 8]);
                sent++;
            end else begin
                send_byte(8'($urandom_range(255)));
                sent++;
            end
        end
    endtask

    initial begin
        int phase;
        int first_random;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        build_script();
        foreach (script[i]) begin
            if (script[i].is_write)
                write_reg(script[i].idx, script[i].value);
            else
                push_item(script[i].item, script[i].typed, script[i].want);
        end

        phase        = 0;
        first_random = items_sent;
        while (items_sent - first_random < RANDOM_ITEMS) begin
            phase++;
            if (phase == 1 || $urandom_range(1))
                write_reg(REG_PATTERN_BYTES, pick_pattern_bytes(phase));
            if (phase == 1 || $urandom_range(1))
                write_reg(REG_PATTERN_LENGTH, 64'(pick_pattern_len()));
            if (phase == 1 || $urandom_range(1))
                write_reg(REG_REPLACEMENT_BYTES, {$urandom, $urandom});
            write_reg(REG_REPLACEMENT_LENGTH, 64'($urandom_range(0, 15)));
            settle();

            // phase 2: hold the receiver off while the sender streams freely
            // phase 4: no idling on either side
            gaps_on  = !(phase == 2 || phase == 4);
            stall_on = (phase != 4);
            if (phase == 2) hold_asks++;
            send_random_phase((phase == 2) ? 60 : $urandom_range(20, 45), phase == 3);
            gaps_on  = 1'b1;
            stall_on = 1'b1;
        end

        settle();
        repeat (4 * SETTLE_CYCLES) @(negedge aclk);
        $display("run covered %0d items, %0d output items checked, %0d register writes",
                 items_sent, results_seen, reg_writes);
        $display("  %0d matches and %0d flushes over %0d random phases",
                 match_count, flush_count, phase);
        if (errors == 0 && pending_chars.size() == 0) begin
            $display("TB_OK");
        end else begin
            if (pending_chars.size() != 0)
                report($sformatf("%0d expected items never arrived", pending_chars.size()));
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/sfr_pkg.sv
design/sfr_front.sv
design/sfr_queue.sv
design/sfr_back.sv
design/stream_find_replace_unit.sv
test/stream_find_replace_unit_tb.sv
